/* src/ntp_pkg.sv */
// Shared types and constants for the number text parser.
`timescale 1ns / 1ps
`default_nettype none

package ntp_pkg;

    localparam int MAX_CHARS_DEF = 11;
    localparam int POS_W         = 4;
    localparam int VAL_W         = 32;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LF   = 8'h66;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UF   = 8'h46;
    localparam logic [7:0] CH_LX   = 8'h78;
    localparam logic [7:0] CH_UX   = 8'h58;
    localparam logic [7:0] CH_LK   = 8'h6B;
    localparam logic [7:0] CH_UK   = 8'h4B;
    localparam logic [7:0] CH_LM   = 8'h6D;
    localparam logic [7:0] CH_UM   = 8'h4D;

    localparam int KILO_SHIFT = 10;
    localparam int MEGA_SHIFT = 20;
    localparam int HEX_SHIFT  = 4;

    typedef enum logic [2:0] {
        CLS_NUL,
        CLS_DIG,
        CLS_HEXL,
        CLS_X,
        CLS_K,
        CLS_M,
        CLS_OTHER
    } cls_t;

    // one classified character
    typedef struct packed {
        logic       first;
        cls_t       cls;
        logic [3:0] digit;
    } tok_t;

endpackage

`default_nettype wire

/* src/ntp_front.sv */
// Front end: takes characters and turns them into class tokens.
`timescale 1ns / 1ps
`default_nettype none

module ntp_front
    import ntp_pkg::*;
(
    input  wire logic [7:0] ch,
    input  wire logic       first,
    input  wire logic       push,
    output logic            full,
    input  wire logic       q_full,
    output logic            q_push,
    output tok_t            q_tok
);

    cls_t       cls;
    logic [3:0] digit;

    always_comb
    begin
        cls   = CLS_OTHER;
        digit = ch[3:0];
        priority if (ch == CH_NUL)
            cls = CLS_NUL;
        else if (ch >= CH_0 && ch <= CH_9)
            cls = CLS_DIG;
        else if ((ch >= CH_LA && ch <= CH_LF) || (ch >= CH_UA && ch <= CH_UF))
        begin
            cls   = CLS_HEXL;
            // 'a'/'A' have low nibble 1, so +9 gives 10..15
            digit = ch[3:0] + 4'd9;
        end
        else if (ch == CH_LX || ch == CH_UX)
            cls = CLS_X;
        else if (ch == CH_LK || ch == CH_UK)
            cls = CLS_K;
        else if (ch == CH_LM || ch == CH_UM)
            cls = CLS_M;
        else
            cls = CLS_OTHER;
    end

    assign full        = q_full;
    assign q_push      = push && !q_full;
    assign q_tok.first = first;
    assign q_tok.cls   = cls;
    assign q_tok.digit = digit;

endmodule

`default_nettype wire

/* src/ntp_fifo.sv */
// Short token queue between front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module ntp_fifo
    import ntp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire tok_t wr_tok,
    output logic      q_full,
    input  wire logic rd_en,
    output tok_t      rd_tok,
    output logic      q_empty
);

    tok_t                  mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_PTR_W:0]   cnt_reg, cnt_next;
    logic                  do_wr, do_rd;

    assign q_full  = (cnt_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_tok  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

/* src/ntp_back.sv */
// Back end: parse state machine and result register.
`timescale 1ns / 1ps
`default_nettype none

module ntp_back
    import ntp_pkg::*;
#(
    parameter int MAX_CHARS = MAX_CHARS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tok_t              tok,
    input  wire logic              q_empty,
    output logic                   q_pop,
    output logic [VAL_W-1:0]       value,
    output logic                   ok,
    output logic                   empty,
    input  wire logic              pop
);

    typedef enum logic [1:0] {
        PH_DONE,
        PH_ZERO,
        PH_DEC,
        PH_HEX
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [VAL_W-1:0]   acc_reg, acc_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]   value_reg, value_next;
    logic               ok_reg, ok_next;

    logic               take;
    logic               run_dec, run_hex;
    logic [VAL_W-1:0]   base_acc, acc_dec, acc_hex;
    logic [POS_W-1:0]   base_pos, pos_inc;
    logic               pos_over;
    logic               res_fire, res_ok;
    logic [VAL_W-1:0]   res_val;

    assign take  = !q_empty && (!out_valid_reg || pop);
    assign q_pop = take;
    assign empty = !out_valid_reg;
    assign value = value_reg;
    assign ok    = ok_reg;

    assign base_acc = tok.first ? '0 : acc_reg;
    assign base_pos = tok.first ? '0 : pos_reg;
    assign pos_inc  = base_pos + 1'b1;
    assign pos_over = (pos_inc >= POS_W'(MAX_CHARS));
    assign acc_dec  = (base_acc << 3) + (base_acc << 1) + {{(VAL_W-4){1'b0}}, tok.digit};
    assign acc_hex  = (base_acc << HEX_SHIFT) + {{(VAL_W-4){1'b0}}, tok.digit};

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        pos_next   = pos_reg;
        run_dec    = 1'b0;
        run_hex    = 1'b0;
        res_fire   = 1'b0;
        res_ok     = 1'b0;
        res_val    = '0;

        if (take)
        begin
            if (tok.first)
            begin
                acc_next = '0;
                pos_next = '0;
                if (tok.cls == CLS_DIG && tok.digit == 4'd0)
                begin
                    pos_next   = POS_W'(1);
                    phase_next = PH_ZERO;
                end
                else
                    run_dec = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_ZERO:
                    begin
                        if (tok.cls == CLS_X)
                        begin
                            pos_next   = POS_W'(2);
                            phase_next = PH_HEX;
                        end
                        else
                            run_dec = 1'b1;
                    end
                    PH_DEC:  run_dec = 1'b1;
                    PH_HEX:  run_hex = 1'b1;
                    PH_DONE: ;
                    default: ;
                endcase
            end

            if (run_dec)
            begin
                phase_next = PH_DEC;
                unique case (tok.cls)
                    CLS_NUL:
                    begin
                        res_fire = 1'b1;
                        res_ok   = 1'b1;
                        res_val  = base_acc;
                    end
                    CLS_K, CLS_M:
                    begin
                        res_fire = 1'b1;
                        if (base_pos != '0)
                        begin
                            res_ok  = 1'b1;
                            res_val = (tok.cls == CLS_K) ? (base_acc << KILO_SHIFT)
                                                         : (base_acc << MEGA_SHIFT);
                        end
                    end
                    CLS_DIG:
                    begin
                        acc_next = acc_dec;
                        pos_next = pos_inc;
                        res_fire = pos_over;
                    end
                    default: res_fire = 1'b1;
                endcase
            end

            if (run_hex)
            begin
                unique case (tok.cls)
                    CLS_NUL:
                    begin
                        res_fire = 1'b1;
                        res_ok   = (base_pos > POS_W'(2));
                        res_val  = res_ok ? base_acc : '0;
                    end
                    CLS_DIG, CLS_HEXL:
                    begin
                        acc_next = acc_hex;
                        pos_next = pos_inc;
                        res_fire = pos_over;
                    end
                    default: res_fire = 1'b1;
                endcase
            end

            if (res_fire)
                phase_next = PH_DONE;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        ok_next        = ok_reg;
        if (res_fire)
        begin
            out_valid_next = 1'b1;
            value_next     = res_val;
            ok_next        = res_ok;
        end
        else if (pop && out_valid_reg)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        ok_reg    <= ok_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_DONE;
            acc_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

/* src/number_text_parser.sv */
// Top level of the number text parser.
// Takes a number as text, one character per word, with first marking the start of a
// string. "0x"/"0X" starts a hex number of up to MAX_CHARS-3 digits; anything else is
// decimal of up to MAX_CHARS-1 digits, wrapping modulo 2^32, where a k/K or m/M after a
// digit scales by 2^10 or 2^20 and ends the string. A NUL ends the string too. Each
// string gives one result word (value, ok); value is 0 when ok is 0, and characters
// after a result are dropped until the next first. One character is taken per clock
// while full is low; the character that ends the string passes through the token queue
// and the result register before its result shows on the output. A four-entry token
// queue lets input keep flowing while the result side is stalled, until the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module number_text_parser
    import ntp_pkg::*;
#(
    parameter int MAX_CHARS = MAX_CHARS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [7:0]       ch,
    input  wire logic             first,
    input  wire logic             push,
    output logic                  full,
    output logic [VAL_W-1:0]      value,
    output logic                  ok,
    output logic                  empty,
    input  wire logic             pop
);

    tok_t wr_tok, rd_tok;
    logic q_push, q_full, q_pop, q_empty;

    ntp_front u_front (
        .ch     (ch),
        .first  (first),
        .push   (push),
        .full   (full),
        .q_full (q_full),
        .q_push (q_push),
        .q_tok  (wr_tok)
    );

    ntp_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_tok  (wr_tok),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_tok  (rd_tok),
        .q_empty (q_empty)
    );

    ntp_back #(
        .MAX_CHARS (MAX_CHARS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .tok     (rd_tok),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .value   (value),
        .ok      (ok),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

`default_nettype wire
